### rtl/core/crc8_framed_packet_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet receiver checker.
// Both macros expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CRC8FR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc8fr: same-cycle check failed");

// Next-cycle implication.
`define CRC8FR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc8fr: next-cycle check failed");

`endif

### rtl/core/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, constants and the CRC-8 byte update for the packet receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

  localparam int NumChannels       = 10;
  localparam int ChW               = $clog2(NumChannels);
  localparam int PayloadLenDefault = 10;
  localparam int QueueDepth        = 2;

  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegStartMarker = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStopMarker  = 1'b1;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'hFF;
  localparam logic [ByteW-1:0] StopMarkerRst  = 8'hFE;

  // Held values after reset: lower half centered low, upper half high
  localparam logic [ByteW-1:0] HeldLowRst  = 8'd90;
  localparam logic [ByteW-1:0] HeldHighRst = 8'd180;
  localparam int               HeldSplit   = 5;

  // Reflected form of polynomial 0x31
  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  // Output stream packing
  localparam int MDataW = 16;
  localparam int AngleLsb = ChW;

  // One report request from the front end to the reporter
  typedef struct packed {
    logic                                  bad;
    logic [NumChannels-1:0][ByteW-1:0]     payload;
  } cmd_t;

  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/crc8fr_front.sv
// ----------------------------------------------------------------------------
// crc8fr_front
// Frame parser: hunts the start byte, captures payload and check byte, runs
// the CRC, and queues a report request on the stop byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_front #(
  parameter int PAYLOAD_LEN = crc8fr_pkg::PayloadLenDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [crc8fr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [crc8fr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                                 byte_valid_i,
  input  wire  [crc8fr_pkg::ByteW-1:0]        byte_i,
  output logic                                byte_ready_o,
  input  wire                                 full_i,
  output logic                                push_o,
  output crc8fr_pkg::cmd_t                    cmd_o
);

  localparam int CntW     = $clog2(PAYLOAD_LEN + 1);
  localparam int StoreLen = (PAYLOAD_LEN < crc8fr_pkg::NumChannels) ?
                            PAYLOAD_LEN : crc8fr_pkg::NumChannels;

  typedef enum logic [2:0] {
    StHunt    = 3'b001,
    StCapture = 3'b010,
    StWait    = 3'b100
  } state_e;

  state_e                                state_q, state_d;
  logic [CntW-1:0]                       cnt_q, cnt_d;
  logic [crc8fr_pkg::ByteW-1:0]          crc_q, crc_d;
  logic [crc8fr_pkg::ByteW-1:0]          start_q, stop_q;
  logic [crc8fr_pkg::ByteW-1:0]          check_q;
  logic [crc8fr_pkg::NumChannels-1:0][crc8fr_pkg::ByteW-1:0] payload_q;
  logic                                  accept;
  logic                                  in_payload;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign in_payload   = (cnt_q < CntW'(PAYLOAD_LEN));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    push_o  = 1'b0;
    if (accept) begin
      case (state_q)
        StCapture: begin
          if (in_payload) begin
            crc_d = crc8fr_pkg::crc8_update(crc_q, byte_i);
            cnt_d = cnt_q + CntW'(1);
          end else begin
            state_d = StWait;
            cnt_d   = '0;
          end
        end
        StWait: begin
          if (byte_i == stop_q) begin
            push_o  = 1'b1;
            state_d = StHunt;
            cnt_d   = '0;
            crc_d   = '0;
          end
        end
        default: begin
          state_d = StHunt;
          if (byte_i == start_q) begin
            state_d = StCapture;
            cnt_d   = '0;
            crc_d   = '0;
          end
        end
      endcase
    end
  end

  assign cmd_o.bad     = (crc_q != check_q);
  assign cmd_o.payload = payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
      cnt_q   <= '0;
      crc_q   <= '0;
      start_q <= crc8fr_pkg::StartMarkerRst;
      stop_q  <= crc8fr_pkg::StopMarkerRst;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          crc8fr_pkg::RegStartMarker: start_q <= cfg_data_i;
          crc8fr_pkg::RegStopMarker:  stop_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload and check byte: no reset, always written before a report reads them
  always_ff @(posedge clk_i) begin
    if (accept && (state_q == StCapture)) begin
      if (cnt_q < CntW'(StoreLen)) begin
        payload_q[crc8fr_pkg::ChW'(cnt_q)] <= byte_i;
      end
      if (!in_payload) begin
        check_q <= byte_i;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/crc8fr_fifo.sv
// ----------------------------------------------------------------------------
// crc8fr_fifo
// Short queue of report requests between the parser and the reporter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_fifo #(
  parameter int DEPTH = crc8fr_pkg::QueueDepth
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire crc8fr_pkg::cmd_t  wdata_i,
  input  wire                    pop_i,
  output crc8fr_pkg::cmd_t       rdata_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  crc8fr_pkg::cmd_t  mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

### rtl/core/crc8fr_back.sv
// ----------------------------------------------------------------------------
// crc8fr_back
// Reporter: walks the channels of one report request, one word per cycle
// while the output is not stalled, and keeps the held value of every channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_back #(
  parameter int PAYLOAD_LEN = crc8fr_pkg::PayloadLenDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire crc8fr_pkg::cmd_t            cmd_i,
  input  wire                              empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [crc8fr_pkg::ChW-1:0]       out_channel_o,
  output logic [crc8fr_pkg::ByteW-1:0]     out_angle_o,
  output logic                             out_bad_o,
  output logic                             out_last_o
);

  localparam int ChW     = crc8fr_pkg::ChW;
  localparam int RptLen  = (PAYLOAD_LEN < crc8fr_pkg::NumChannels) ?
                           PAYLOAD_LEN : crc8fr_pkg::NumChannels;
  localparam logic [ChW-1:0] LastCh = ChW'(crc8fr_pkg::NumChannels - 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e                                 state_q, state_d;
  logic [ChW-1:0]                         ch_q, ch_d;
  logic [crc8fr_pkg::NumChannels-1:0][crc8fr_pkg::ByteW-1:0] held_q;
  logic                                   out_free;
  logic                                   emit;
  logic [crc8fr_pkg::ByteW-1:0]           value;

  assign out_free = !out_valid_o || out_ready_i;
  assign emit     = (state_q == StRun) && out_free;
  assign value    = (!cmd_i.bad && (ch_q < ChW'(RptLen))) ? cmd_i.payload[ch_q]
                                                          : held_q[ch_q];
  assign pop_o    = emit && (ch_q == LastCh);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StRun;
          ch_d    = '0;
        end
      end
      StRun: begin
        if (emit) begin
          if (ch_q == LastCh) state_d = StIdle;
          else                ch_d    = ch_q + ChW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_q        <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < crc8fr_pkg::NumChannels; i++) begin
        held_q[i] <= (i < crc8fr_pkg::HeldSplit) ? crc8fr_pkg::HeldLowRst
                                                 : crc8fr_pkg::HeldHighRst;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (out_free) out_valid_o <= emit;
      if (emit)     held_q[ch_q] <= value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_channel_o <= ch_q;
      out_angle_o   <= value;
      out_bad_o     <= cmd_i.bad;
      out_last_o    <= (ch_q == LastCh);
    end
  end

endmodule

`default_nettype wire

### rtl/core/crc8_framed_packet_receiver.sv
// Framed packet receiver with CRC-8 check. Each serial byte is one input
// word. Bytes are dropped until the start marker; then PAYLOAD_LEN payload
// bytes and one check byte are captured whatever their values, and bytes are
// dropped again until the stop marker. The payload CRC (reflected polynomial
// 0x31, init 0) is compared with the check byte, and the stop byte releases a
// report of ten words, channels 0 to 9, one word per cycle from the reporter's
// output register while the sink does not stall. A good packet reports and
// keeps the new values; a bad one reports the held values with crc_bad set.
// The queue between parser and reporter holds two reports, the one being
// walked and one behind it; the input stalls while both places are taken.
// Markers are to be written by the user through the plain configuration port
// only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver
// Top level: parser front end, report queue and reporter back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc8_framed_packet_receiver #(
  parameter int PAYLOAD_LEN = crc8fr_pkg::PayloadLenDefault
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Configuration: index 0 start marker, index 1 stop marker
  input  wire                               cfg_we_i,
  input  wire  [crc8fr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [crc8fr_pkg::CfgDataW-1:0]   cfg_data_i,
  // Received byte stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  // Report stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [crc8fr_pkg::MDataW-1:0]     m_axis_tdata,  // [3:0] channel, [11:4] angle
  output logic                              m_axis_tlast,  // last channel of report
  output logic                              m_axis_tuser   // [0] crc_bad
);

  crc8fr_pkg::cmd_t                 push_cmd;
  crc8fr_pkg::cmd_t                 head_cmd;
  logic                             push;
  logic                             pop;
  logic                             q_full;
  logic                             q_empty;
  logic [crc8fr_pkg::ChW-1:0]       out_channel;
  logic [crc8fr_pkg::ByteW-1:0]     out_angle;

  // Parse the byte stream, compute the CRC, queue a report on the stop byte
  crc8fr_front #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .byte_ready_o (s_axis_tready),
    .full_i       (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Hold pending reports so the parser keeps taking bytes during a report
  crc8fr_fifo #(
    .DEPTH (crc8fr_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Emit one channel word per cycle unless the sink stalls, and update the held values
  crc8fr_back #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (out_channel),
    .out_angle_o   (out_angle),
    .out_bad_o     (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

  // Pack channel and angle, pad to whole bytes with zeros
  assign m_axis_tdata = {
    (crc8fr_pkg::MDataW - crc8fr_pkg::AngleLsb - crc8fr_pkg::ByteW)'(0),
    out_angle,
    out_channel
  };

endmodule

`default_nettype wire

### rtl/core/crc8fr_checker.sv
// ----------------------------------------------------------------------------
// crc8fr_checker
// Port-level checks on the report stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "crc8_framed_packet_receiver_assert.svh"

module crc8fr_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [15:0] m_axis_tdata,
  input  wire         m_axis_tlast,
  input  wire         m_axis_tuser
);

  logic        out_stall;
  logic        mid_take;
  logic [3:0]  out_ch;
  logic [3:0]  next_ch;
  logic [17:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign mid_take  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign out_ch    = m_axis_tdata[3:0];
  assign next_ch   = out_ch + 4'd1;
  assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // A stalled word holds
  `CRC8FR_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

  // tlast marks exactly the final channel
  `CRC8FR_ASSERT_NOW(a_last_on_final, m_axis_tvalid, m_axis_tlast == (out_ch == 4'd9))

  // Within a report the next channel follows at once
  `CRC8FR_ASSERT_NEXT(a_channel_step, mid_take, m_axis_tvalid && out_ch == $past(next_ch))

  // The check result stays the same across one report
  `CRC8FR_ASSERT_NEXT(a_bad_steady, mid_take, $stable(m_axis_tuser))

  // Padding bits stay zero
  `CRC8FR_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:12] == 4'd0)

endmodule

bind crc8_framed_packet_receiver crc8fr_checker u_crc8fr_checker (.*);

`default_nettype wire

### verif/crc8_framed_packet_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_tb
// Feeds framed byte streams into the packet receiver and checks every report
// word against a cycle-free model of the framing, CRC-8 and held-value logic.
// ----------------------------------------------------------------------------

module crc8_framed_packet_receiver_tb;

  import crc8fr_pkg::*;

  localparam int          PayloadBytes     = PayloadLenDefault;
  localparam logic [7:0]  CrcPolyRefl      = 8'h8C;
  localparam int          SettleCycles     = 24;
  localparam int          SinkFreezeCycles = 400;
  localparam int          TimeoutCycles    = 300000;

  typedef enum logic [1:0] {
    HuntStart,
    CaptureBody,
    AwaitStop
  } rx_phase_e;

  // One report word as the model predicts it
  typedef struct {
    logic [ChW-1:0] channel;
    logic [7:0]     angle;
    logic           crc_bad;
    logic           is_last;
  } report_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MDataW-1:0]   m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  crc8_framed_packet_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] channel, [11:4] angle, [15:12] zero
    .m_axis_tlast  (m_axis_tlast),   // last channel of the report
    .m_axis_tuser  (m_axis_tuser)    // [0] crc_bad
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Receiver model: markers, framing state, CRC and the held angle store
  // --------------------------------------------------------------------------
  logic [7:0]   start_marker_m = 8'hFF;
  logic [7:0]   stop_marker_m  = 8'hFE;
  rx_phase_e    rx_phase       = HuntStart;
  int           body_count     = 0;
  logic [7:0]   crc_m          = 8'h00;
  logic [7:0]   check_m        = 8'h00;
  logic [7:0]   body_m [PayloadBytes];
  logic [7:0]   held_m [NumChannels];

  report_word_t pending_reports[$];
  logic [7:0]   rx_backlog[$];
  int           n_pushed       = 0;
  int           n_accepted     = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;

  // Stimulus controls, changed only away from the rising edge or by NBA
  bit           idle_on        = 1'b1;
  bit           freeze_req     = 1'b0;
  logic         sink_frozen    = 1'b0;
  int           src_gap        = 0;
  int           sink_gap       = 0;

  initial begin
    for (int ch = 0; ch < NumChannels; ch++) begin
      held_m[ch] = (ch < 5) ? 8'd90 : 8'd180;
    end
    for (int i = 0; i < PayloadBytes; i++) begin
      body_m[i] = 8'h00;
    end
  end

  // Dallas/Maxim CRC-8, fed LSB first one bit at a time
  function automatic logic [7:0] crc8_maxim_step(input logic [7:0] acc,
                                                 input logic [7:0] b);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CrcPolyRefl;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Advance the model by one accepted byte; a stop byte queues ten words
  task automatic absorb_rx_byte(input logic [7:0] b);
    report_word_t w;
    logic         crc_fail;
    case (rx_phase)
      CaptureBody: begin
        if (body_count < PayloadBytes) begin
          body_m[body_count] = b;
          crc_m              = crc8_maxim_step(crc_m, b);
          body_count++;
        end else begin
          check_m    = b;
          body_count = 0;
          rx_phase   = AwaitStop;
        end
      end
      AwaitStop: begin
        if (b == stop_marker_m) begin
          crc_fail = (crc_m != check_m);
          for (int ch = 0; ch < NumChannels; ch++) begin
            // a good packet overwrites the held store, a bad one keeps it
            if (!crc_fail && ch < PayloadBytes) begin
              held_m[ch] = body_m[ch];
            end
            w.channel = ChW'(ch);
            w.angle   = held_m[ch];
            w.crc_bad = crc_fail;
            w.is_last = (ch == NumChannels - 1);
            pending_reports.push_back(w);
          end
          rx_phase   = HuntStart;
          body_count = 0;
          crc_m      = 8'h00;
        end
      end
      default: begin
        rx_phase = HuntStart;
        if (b == start_marker_m) begin
          rx_phase   = CaptureBody;
          body_count = 0;
          crc_m      = 8'h00;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer bytes from the backlog, idle in bursts between words
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_driver
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_rx_byte(s_axis_tdata);
        n_accepted++;
      end
      // hold the offered word until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 18);
          s_axis_tvalid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver side: check each report word, stall in bursts or when frozen
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : report_monitor
    report_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%t: unexpected report word: expected none, actual tdata %h last %b user %b",
                   $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          want = pending_reports.pop_front();
          if (m_axis_tdata[ChW-1:0] !== want.channel) begin
            mismatch_count++;
            $display("%t: channel: expected %0d, actual %0d",
                     $realtime, want.channel, m_axis_tdata[ChW-1:0]);
          end
          if (m_axis_tdata[AngleLsb +: 8] !== want.angle) begin
            mismatch_count++;
            $display("%t: angle (ch %0d): expected %0d, actual %0d",
                     $realtime, want.channel, want.angle, m_axis_tdata[AngleLsb +: 8]);
          end
          if (m_axis_tdata[MDataW-1:AngleLsb+8] !== '0) begin
            mismatch_count++;
            $display("%t: tdata padding: expected 0, actual %h",
                     $realtime, m_axis_tdata[MDataW-1:AngleLsb+8]);
          end
          if (m_axis_tuser !== want.crc_bad) begin
            mismatch_count++;
            $display("%t: crc_bad (ch %0d): expected %b, actual %b",
                     $realtime, want.channel, want.crc_bad, m_axis_tuser);
          end
          if (m_axis_tlast !== want.is_last) begin
            mismatch_count++;
            $display("%t: last (ch %0d): expected %b, actual %b",
                     $realtime, want.channel, want.is_last, m_axis_tlast);
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (sink_frozen) begin
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing bytes
  initial begin : sink_freeze
    wait (freeze_req);
    @(posedge clk_i);
    sink_frozen <= 1'b1;
    repeat (SinkFreezeCycles) @(posedge clk_i);
    sink_frozen <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= TimeoutCycles) begin
      $display("%t: timeout with %0d report words outstanding",
               $realtime, pending_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    n_pushed++;
  endtask

  // Junk, start, body, check, junk, stop; junk never matches the marker near it
  task automatic push_frame(input logic [7:0] body [PayloadBytes], input logic [7:0] check,
                            input int lead, input int tail);
    logic [7:0] b;
    for (int i = 0; i < lead; i++) begin
      b = 8'($urandom);
      push_byte((b == start_marker_m) ? b ^ 8'h01 : b);
    end
    push_byte(start_marker_m);
    for (int i = 0; i < PayloadBytes; i++) begin
      push_byte(body[i]);
    end
    push_byte(check);
    for (int i = 0; i < tail; i++) begin
      b = 8'($urandom);
      push_byte((b == stop_marker_m) ? b ^ 8'h01 : b);
    end
    push_byte(stop_marker_m);
  endtask

  // Random body, markers sprinkled in; a bad packet gets a corrupted check byte
  task automatic push_random_packet(input bit crc_ok);
    logic [7:0] body [PayloadBytes];
    logic [7:0] acc;
    int         pick;
    acc = 8'h00;
    for (int i = 0; i < PayloadBytes; i++) begin
      pick = $urandom_range(0, 9);
      body[i] = (pick == 0) ? start_marker_m : (pick == 1) ? stop_marker_m : 8'($urandom);
      acc = crc8_maxim_step(acc, body[i]);
    end
    if (!crc_ok) begin
      acc = acc ^ 8'($urandom_range(1, 255));
    end
    push_frame(body, acc, $urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  // Mostly good packets, some bad ones, and now and then raw noise that may
  // open a frame early and break the next one
  task automatic push_random_packets(input int count, input bit with_noise);
    int roll;
    int noise_len;
    for (int p = 0; p < count; p++) begin
      roll = $urandom_range(0, 9);
      if (with_noise && roll == 0) begin
        noise_len = $urandom_range(1, 12);
        for (int i = 0; i < noise_len; i++) begin
          push_byte(8'($urandom));
        end
      end
      push_random_packet(roll < 7);
    end
  endtask

  // Wait until every byte is taken and every report word seen, then settle
  task automatic drain_and_settle();
    while (n_accepted != n_pushed || pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == RegStartMarker) begin
      start_marker_m = value;
    end else if (idx == RegStopMarker) begin
      stop_marker_m = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] start_v, input logic [7:0] stop_v);
    write_marker(RegStartMarker, start_v);
    write_marker(RegStopMarker, stop_v);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [7:0] body [PayloadBytes];
    logic [7:0] acc;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset markers: byte extremes and both markers inside the
    // body, a good CRC, then a bad packet whose check byte is 169
    body = '{8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'd169, 8'hAA, 8'h55, 8'h00};
    acc  = 8'h00;
    for (int i = 0; i < PayloadBytes; i++) begin
      acc = crc8_maxim_step(acc, body[i]);
    end
    push_frame(body, acc, 1, 1);
    body = '{8'hFF, 8'hFF, 8'h00, 8'hFE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
    push_frame(body, 8'd169, 0, 0);
    drain_and_settle();

    // Random markers
    set_markers(8'($urandom), 8'($urandom));
    push_random_packets(5, 1'b1);
    drain_and_settle();

    // Marker extremes; pause the sender mid-way until all reports are out
    set_markers(8'h00, 8'hFF);
    push_random_packets(2, 1'b1);
    drain_and_settle();
    @(negedge clk_i);
    push_random_packets(3, 1'b1);
    drain_and_settle();

    // Start and stop share one value
    set_markers(8'hFF, 8'hFF);
    push_random_packets(5, 1'b1);
    drain_and_settle();

    // Freeze the receiver while clean packets keep coming: fill the report
    // queue until the input stalls
    set_markers(8'($urandom), 8'($urandom));
    freeze_req = 1'b1;
    push_random_packets(7, 1'b0);
    drain_and_settle();

    // Back-to-back traffic with no idling on either side
    set_markers(8'h00, 8'h00);
    idle_on = 1'b0;
    push_random_packets(3, 1'b1);
    drain_and_settle();

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/crc8fr_pkg.sv
rtl/core/crc8fr_front.sv
rtl/core/crc8fr_fifo.sv
rtl/core/crc8fr_back.sv
rtl/core/crc8_framed_packet_receiver.sv
rtl/core/crc8fr_checker.sv
verif/crc8_framed_packet_receiver_tb.sv
